// ===== rtl/sqg_pkg.sv =====
// Shared types, constants and the envelope table builder for the squelch ramp gate.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps

package sqg_pkg;

    localparam int TABLE_SIZE  = 1024;
    localparam int IDX_BITS    = $clog2(TABLE_SIZE);
    localparam int IDX_W       = IDX_BITS + 1;
    localparam int RAMP_BITS   = 11;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [RAMP_BITS-1:0] MAX_RAMP = 11'd1024;
    localparam logic [RAMP_BITS-1:0] POS_MAX  = 11'd2047;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;

    // squelch modes
    localparam logic [1:0] MODE_MUTED   = 2'd0;
    localparam logic [1:0] MODE_ATTACK  = 2'd1;
    localparam logic [1:0] MODE_UNMUTED = 2'd2;
    localparam logic [1:0] MODE_DECAY   = 2'd3;

    // what the back end does to the envelope gain
    localparam logic [1:0] GAIN_KEEP = 2'd0;
    localparam logic [1:0] GAIN_SET1 = 2'd1;
    localparam logic [1:0] GAIN_SET0 = 2'd2;
    localparam logic [1:0] GAIN_ENV  = 2'd3;

    // what the back end sends out
    localparam logic [1:0] EMIT_NONE   = 2'd0;
    localparam logic [1:0] EMIT_ZERO   = 2'd1;
    localparam logic [1:0] EMIT_SCALED = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_LENGTH = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_DROP   = 4'd1;

    typedef struct packed {
        logic [1:0]           gain_op;
        logic [1:0]           emit;
        logic [RAMP_BITS-1:0] pos;
        logic [RAMP_BITS-1:0] ramp;
    } sqg_cmd_t;

    typedef struct packed {
        logic                 finishing;
        logic [GAIN_BITS-1:0] gain;
    } sqg_back_status_t;

    // Raised-cosine entry in Q30 via a folded Taylor series, rounded to Q1.15.
    function automatic logic [GAIN_BITS-1:0] sqg_rom_entry(input int n);
        logic   neg;
        longint m;
        longint y;
        longint y2;
        longint t;
        longint e;
        neg = (2 * n) > TABLE_SIZE;
        m   = neg ? longint'(TABLE_SIZE - n) : longint'(n);
        y   = (PI_Q30 * m) / TABLE_SIZE;
        y2  = (y * y) / Q30_ONE;
        t   = Q30_ONE;
        t   = Q30_ONE - ((y2 * t) / Q30_ONE) / 132;
        t   = Q30_ONE - ((y2 * t) / Q30_ONE) / 90;
        t   = Q30_ONE - ((y2 * t) / Q30_ONE) / 56;
        t   = Q30_ONE - ((y2 * t) / Q30_ONE) / 30;
        t   = Q30_ONE - ((y2 * t) / Q30_ONE) / 12;
        t   = Q30_ONE - ((y2 * t) / Q30_ONE) / 2;
        e   = neg ? (Q30_ONE + t) / 2 : (Q30_ONE - t) / 2;
        if (e < 0)
        begin
            e = 0;
        end
        if (e > Q30_ONE)
        begin
            e = Q30_ONE;
        end
        return GAIN_BITS'((e + 64'sd16384) >>> GAIN_FRAC);
    endfunction

endpackage

// ===== rtl/sqg_fifo.sv =====
// Small request queue between the front and back ends of the squelch ramp gate.
// Depends on nothing but its parameters; show-ahead read.
`timescale 1ns / 1ps

module sqg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem [0:DEPTH-1];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sqg_front.sv =====
// Front end of the squelch ramp gate: accepts samples, runs the squelch mode
// and ramp position, and queues one request per sample. Uses sqg_pkg.
`timescale 1ns / 1ps

module sqg_front import sqg_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mute_request,
    input  logic [RAMP_BITS-1:0] ramp_length,
    input  logic                 gate_drop,
    input  logic                 push_ready,
    output logic                 push,
    output sqg_cmd_t             cmd
);

    logic [1:0]           mode_reg;
    logic [1:0]           mode_next;
    logic [RAMP_BITS-1:0] pos_reg;
    logic [RAMP_BITS-1:0] pos_next;
    logic [RAMP_BITS-1:0] ramp_eff;
    logic [RAMP_BITS-1:0] pos_inc;
    logic [RAMP_BITS-1:0] pos_dec;

    assign in_stall = !push_ready;
    assign push     = in_valid && push_ready;

    always_comb
    begin
        ramp_eff    = (ramp_length > MAX_RAMP) ? MAX_RAMP : ramp_length;
        pos_inc     = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        pos_dec     = pos_reg - 1'b1;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        cmd.gain_op = GAIN_KEEP;
        cmd.pos     = pos_reg;
        cmd.ramp    = ramp_eff;
        case (mode_reg)
            MODE_MUTED:
            begin
                if (!mute_request)
                begin
                    if (ramp_eff != '0)
                    begin
                        mode_next = MODE_ATTACK;
                    end
                    else
                    begin
                        mode_next   = MODE_UNMUTED;
                        cmd.gain_op = GAIN_SET1;
                    end
                end
            end
            MODE_UNMUTED:
            begin
                if (mute_request)
                begin
                    mode_next = (ramp_eff != '0) ? MODE_DECAY : MODE_MUTED;
                end
            end
            MODE_ATTACK:
            begin
                pos_next = pos_inc;
                if (ramp_eff == '0 || pos_inc >= ramp_eff)
                begin
                    mode_next   = MODE_UNMUTED;
                    cmd.gain_op = GAIN_SET1;
                end
                else
                begin
                    cmd.gain_op = GAIN_ENV;
                    cmd.pos     = pos_inc;
                end
            end
            default:
            begin
                // decay: finish at once on a hard switch or an exhausted ramp
                if (ramp_eff == '0 || pos_reg == '0)
                begin
                    pos_next    = '0;
                    mode_next   = MODE_MUTED;
                    cmd.gain_op = GAIN_SET0;
                end
                else
                begin
                    pos_next    = pos_dec;
                    cmd.gain_op = GAIN_ENV;
                    cmd.pos     = pos_dec;
                    if (pos_dec == '0)
                    begin
                        mode_next = MODE_MUTED;
                    end
                end
            end
        endcase
        if (mode_next != MODE_MUTED)
        begin
            cmd.emit = EMIT_SCALED;
        end
        else
        begin
            cmd.emit = gate_drop ? EMIT_NONE : EMIT_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MUTED;
            pos_reg  <= '0;
        end
        else if (push)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== rtl/sqg_back.sv =====
// Back end of the squelch ramp gate: shift-subtract table index divide, envelope
// ROM, scaling with rounding and saturation, output register. Uses sqg_pkg.
`timescale 1ns / 1ps

module sqg_back import sqg_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sqg_cmd_t                      q_cmd,
    input  logic signed [SAMPLE_BITS-1:0] q_i,
    input  logic signed [SAMPLE_BITS-1:0] q_q,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_i,
    output logic signed [SAMPLE_BITS-1:0] out_q,
    output sqg_back_status_t              status
);

    localparam int PW       = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int CNT_BITS = $clog2(IDX_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(IDX_BITS - 1);
    localparam logic [IDX_W-1:0]    IDX_FULL = IDX_W'(TABLE_SIZE);
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) << (GAIN_FRAC - 1);
    localparam logic signed [PW-1:0] SAT_MAX = (PW'(1) << (SAMPLE_BITS - 1)) - PW'(1);
    localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_ROM  = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_DONE = 3'd4;

    logic [GAIN_BITS-1:0] rom [0:TABLE_SIZE];

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [GAIN_BITS-1:0]          gain_reg;
    logic                          out_valid_reg;
    logic [1:0]                    emit_reg;
    logic signed [SAMPLE_BITS-1:0] x_i_reg;
    logic signed [SAMPLE_BITS-1:0] x_q_reg;
    logic [RAMP_BITS-1:0]          ramp_reg;
    logic [RAMP_BITS-1:0]          rem_reg;
    logic [RAMP_BITS-1:0]          rem_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic signed [PW-1:0]          prod_i_reg;
    logic signed [PW-1:0]          prod_q_reg;
    logic signed [SAMPLE_BITS-1:0] out_i_reg;
    logic signed [SAMPLE_BITS-1:0] out_q_reg;
    logic [RAMP_BITS:0]            rem_dbl;
    logic                          div_ge;
    logic                          load_out;
    logic signed [GAIN_BITS:0]     gain_s;
    logic signed [SAMPLE_BITS-1:0] sat_i;
    logic signed [SAMPLE_BITS-1:0] sat_q;

    for (genvar n = 0; n <= TABLE_SIZE; n++)
    begin : g_rom
        assign rom[n] = sqg_rom_entry(n);
    end

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [PW-1:0] p
    );
        logic signed [PW-1:0] r;
        r = (p + ROUND_BIAS) >>> GAIN_FRAC;
        if (r > SAT_MAX)
        begin
            r = SAT_MAX;
        end
        else if (r < SAT_MIN)
        begin
            r = SAT_MIN;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    assign gain_s    = {1'b0, gain_reg};
    assign sat_i     = round_sat(prod_i_reg);
    assign sat_q     = round_sat(prod_q_reg);
    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;
    assign status.finishing = load_out;
    assign status.gain      = gain_reg;

    // one quotient bit of floor(k * TABLE_SIZE / ramp) a cycle, remainder kept below ramp
    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        div_ge   = rem_dbl >= {1'b0, ramp_reg};
        rem_next = div_ge ? RAMP_BITS'(rem_dbl - {1'b0, ramp_reg}) : rem_dbl[RAMP_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (q_cmd.gain_op == GAIN_ENV)
                    begin
                        state_next = (q_cmd.pos >= q_cmd.ramp) ? B_ROM : B_DIV;
                    end
                    else
                    begin
                        state_next = B_MUL;
                    end
                end
            end
            B_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = B_ROM;
                end
            end
            B_ROM:
            begin
                state_next = B_MUL;
            end
            B_MUL:
            begin
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (emit_reg == EMIT_NONE)
                begin
                    state_next = B_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            gain_reg      <= GAIN_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && q_cmd.gain_op == GAIN_SET1)
            begin
                gain_reg <= GAIN_ONE;
            end
            else if (pop && q_cmd.gain_op == GAIN_SET0)
            begin
                gain_reg <= '0;
            end
            else if (state_reg == B_ROM)
            begin
                gain_reg <= rom[idx_reg];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            emit_reg <= q_cmd.emit;
            x_i_reg  <= q_i;
            x_q_reg  <= q_q;
            ramp_reg <= q_cmd.ramp;
            rem_reg  <= q_cmd.pos;
            cnt_reg  <= '0;
            // saturate the index when the position has run past the ramp
            idx_reg  <= (q_cmd.pos >= q_cmd.ramp) ? IDX_FULL : '0;
        end
        else if (state_reg == B_DIV)
        begin
            rem_reg <= rem_next;
            idx_reg <= {idx_reg[IDX_BITS-1:0], div_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == B_MUL)
        begin
            prod_i_reg <= x_i_reg * gain_s;
            prod_q_reg <= x_q_reg * gain_s;
        end
        if (load_out)
        begin
            out_i_reg <= (emit_reg == EMIT_ZERO) ? '0 : sat_i;
            out_q_reg <= (emit_reg == EMIT_ZERO) ? '0 : sat_q;
        end
    end

endmodule

// ===== rtl/squelch_ramp_gate.sv =====
// Squelch gate with raised-cosine attack and decay ramps (top level).
// Path: the back end pops a request, runs the shift-subtract divide and the envelope
// ROM lookup when the sample needs one (only the lookup when the table index
// saturates), then the multiply and the output register; a held output stall holds it.
// The back end takes a new sample only after it has finished the last one.
// Reset: muted, unity gain, ramp length 0, gating off; no clearing pass.
`timescale 1ns / 1ps

module squelch_ramp_gate import sqg_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    input  logic                          mute_request,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_i,
    output logic signed [SAMPLE_BITS-1:0] out_q,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int QW = $bits(sqg_cmd_t) + 2 * SAMPLE_BITS;

    logic [RAMP_BITS-1:0]          ramp_length_reg;
    logic                          gate_drop_reg;
    sqg_cmd_t                      cmd;
    sqg_cmd_t                      q_cmd;
    logic signed [SAMPLE_BITS-1:0] q_i;
    logic signed [SAMPLE_BITS-1:0] q_q;
    logic                          push;
    logic                          pop;
    logic                          fifo_full;
    logic                          fifo_empty;
    logic [QW-1:0]                 pop_data;
    sqg_back_status_t              status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_length_reg <= '0;
            gate_drop_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAMP_LENGTH: ramp_length_reg <= cfg_data[RAMP_BITS-1:0];
                CFG_GATE_DROP:   gate_drop_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    sqg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mute_request (mute_request),
        .ramp_length  (ramp_length_reg),
        .gate_drop    (gate_drop_reg),
        .push_ready   (!fifo_full),
        .push         (push),
        .cmd          (cmd)
    );

    sqg_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({cmd, sample_i, sample_q}),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    assign {q_cmd, q_i, q_q} = pop_data;

    sqg_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (fifo_empty),
        .q_cmd     (q_cmd),
        .q_i       (q_i),
        .q_q       (q_q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q),
        .status    (status)
    );

    // an accepted sample is waiting in the queue on the next cycle
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !fifo_empty)
        else $error("accepted sample missing from queue");

    // a result appears only when the back end completes a request
    a_out_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.finishing))
        else $error("result without a completed request");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.gain <= GAIN_ONE)
        else $error("envelope gain above unity");

endmodule
